/* src/alp_pkg.sv */
// Shared types, widths, request codes and register indexes for the
// polyline arc length store. No dependencies.
package alp_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int REQ_W      = 3;
  localparam int POS_W      = 24;
  localparam int DIST_W     = 32;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int ROOT_W     = DIFF_W;
  localparam int PROD_W     = DIFF_W + DIST_W + 1;
  localparam int QUO_W      = DIFF_W;
  localparam int MIN_STEP_W = 8;
  localparam int MARGIN_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [MIN_STEP_W-1:0] MIN_STEP_RST = 8'd1;
  localparam logic [MARGIN_W-1:0]   MARGIN_RST   = 10'd100;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRIM   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_MARGIN = 2'd1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [DIST_W-1:0]       d;
  } point_t;

endpackage

/* src/alp_ifs.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on alp_pkg.
interface alp_in_if;
  logic                              valid;
  logic                              ready;
  logic [alp_pkg::REQ_W-1:0]         req_type;
  logic signed [alp_pkg::POS_W-1:0]  pos_x;
  logic signed [alp_pkg::POS_W-1:0]  pos_y;
  logic signed [alp_pkg::POS_W-1:0]  pos_z;
  logic [alp_pkg::DIST_W-1:0]        dist_req;
  modport source(output valid, req_type, pos_x, pos_y, pos_z, dist_req, input ready);
  modport sink(input valid, req_type, pos_x, pos_y, pos_z, dist_req, output ready);
endinterface

interface alp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [alp_pkg::POS_W-1:0]  out_x;
  logic signed [alp_pkg::POS_W-1:0]  out_y;
  logic signed [alp_pkg::POS_W-1:0]  out_z;
  logic [alp_pkg::DIST_W-1:0]        out_dist;
  modport source(output valid, ok, out_x, out_y, out_z, out_dist, input ready);
  modport sink(input valid, ok, out_x, out_y, out_z, out_dist, output ready);
endinterface

/* src/alp_mem.sv */
// Point memory: one write port and one registered read port.
// Depends on alp_pkg for the entry type.
module alp_mem #(
  parameter int DEPTH = alp_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  alp_pkg::point_t      wdata,
  input  logic [AW-1:0]        raddr,
  output alp_pkg::point_t      rdata
);

  alp_pkg::point_t mem [DEPTH];
  alp_pkg::point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/alp_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
// Depends on alp_pkg for default widths.
module alp_sqrt #(
  parameter int ROOT_W = alp_pkg::ROOT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W:0]     rem_r;
  logic [ROOT_W-1:0]   res_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic                take;

  assign rem_sh = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
  assign trial  = {1'b0, res_r, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
        rad_r  <= radicand;
        rem_r  <= '0;
        res_r  <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[2*ROOT_W-3:0], 2'b00};
        if (take) begin
          rem_r <= ROOT_W'(1) == 0 ? '0 : (ROOT_W+1)'(rem_sh - trial);
          res_r <= {res_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r <= (ROOT_W+1)'(rem_sh);
          res_r <= {res_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r;

endmodule

/* src/alp_div.sv */
// Iterative restoring divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUO_W bits. Depends on alp_pkg.
module alp_div #(
  parameter int DEN_W = alp_pkg::DIST_W,
  parameter int QUO_W = alp_pkg::QUO_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DEN_W+QUO_W-1:0]  dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic [QUO_W-1:0]        quotient
);

  localparam int CW = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] lo_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             take;

  assign rem_sh = {rem_r, lo_r[QUO_W-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QUO_W);
        rem_r  <= dividend[DEN_W+QUO_W-1:QUO_W];
        lo_r   <= dividend[QUO_W-1:0];
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= take ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
        lo_r  <= {lo_r[QUO_W-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = lo_r;

endmodule

/* src/polyline_arc_length_store_top.sv */
// Top level of the polyline arc length store: request sequencer around the
// point memory, square root unit and divider. Depends on alp_pkg, alp_ifs,
// alp_mem, alp_sqrt and alp_div.
//
//   Channel  Dir  Handshake           Payload
//   in_req   in   valid/ready         req_type, pos_x, pos_y, pos_z, dist_req
//   out_rsp  out  valid/ready         ok, out_x, out_y, out_z, out_dist
//   cfg_*    in   cfg_we (no wait)    cfg_index, cfg_wdata
//
// One request is worked on at a time. An append waits on the 25-step square
// root. In a query the binary search makes one read of the memory read port
// per probe, and each of the three axes goes through the 25-step divider.
// Reset is synchronous and needs no clearing pass; the memory holds no valid
// data until points are appended. A finished result waits in the output
// register, and the next request is taken while it waits; only the
// completion of a later one stalls on it.
module polyline_arc_length_store_top #(
  parameter int MAX_POINTS = alp_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  alp_in_if.sink                           in_req,
  alp_out_if.source                        out_rsp,
  input  logic                             cfg_we,
  input  logic [alp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (IDX_W > alp_pkg::MARGIN_W) ? IDX_W : alp_pkg::MARGIN_W;
  localparam logic [IDX_W:0]   MAX_SLOT = (IDX_W+1)'(MAX_POINTS);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_POINTS);
  localparam int POS_W  = alp_pkg::POS_W;
  localparam int DIST_W = alp_pkg::DIST_W;
  localparam int DIFF_W = alp_pkg::DIFF_W;
  localparam int SQ_W   = alp_pkg::SQ_W;
  localparam int ROOT_W = alp_pkg::ROOT_W;
  localparam int PROD_W = alp_pkg::PROD_W;
  localparam int QUO_W  = alp_pkg::QUO_W;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_APP_DIF = 17'h00002,
    S_APP_SQ  = 17'h00004,
    S_APP_RT  = 17'h00008,
    S_RD_WT   = 17'h00010,
    S_B_LO    = 17'h00020,
    S_B_HI    = 17'h00040,
    S_B_CHK   = 17'h00080,
    S_B_MID   = 17'h00100,
    S_Q_LO    = 17'h00200,
    S_Q_HI    = 17'h00400,
    S_Q_MUL   = 17'h00800,
    S_Q_DST   = 17'h01000,
    S_Q_DIV   = 17'h02000,
    S_Q_ACC   = 17'h04000,
    S_RESP    = 17'h08000,
    S_SPARE   = 17'h10000
  } state_t;

  // Ring position of logical index i.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] first,
                                               input logic [IDX_W-1:0] i);
    logic [IDX_W:0] s;
    s = {1'b0, first} + {1'b0, i};
    if (s >= MAX_SLOT) begin
      s = s - MAX_SLOT;
    end
    return s[IDX_W-1:0];
  endfunction

  state_t state_r;

  logic [alp_pkg::MIN_STEP_W-1:0] min_step_r;
  logic [alp_pkg::MARGIN_W-1:0]   margin_r;
  logic [CNT_W-1:0]               count_r;
  logic [IDX_W-1:0]               first_r;

  logic [alp_pkg::REQ_W-1:0]      req_r;
  logic signed [POS_W-1:0]        px_r, py_r, pz_r;
  logic [DIST_W-1:0]              dist_r;

  logic signed [DIFF_W-1:0]       dx_r, dy_r, dz_r;
  logic [SQ_W-1:0]                acc_r;
  logic [1:0]                     sel_r;
  logic [DIST_W-1:0]              last_d_r;

  logic [IDX_W-1:0]               lo_r, hi_r, mid_r;
  alp_pkg::point_t                p0_r, p1_r;
  logic [DIST_W-1:0]              num_r, den_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic                           neg_r;
  logic [1:0]                     axis_r;

  logic                           res_ok_r;
  logic signed [POS_W-1:0]        res_x_r, res_y_r, res_z_r;
  logic [DIST_W-1:0]              res_dist_r;

  logic                           out_valid_r;
  logic                           out_ok_r;
  logic signed [POS_W-1:0]        out_x_r, out_y_r, out_z_r;
  logic [DIST_W-1:0]              out_dist_r;

  logic                           in_acc;
  logic [IDX_W-1:0]               last_idx;
  logic [IDX_W-1:0]               span;
  logic [IDX_W-1:0]               mid_w;
  logic [IDX_W-1:0]               rd_idx;
  logic [IDX_W-1:0]               mem_raddr;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  alp_pkg::point_t                mem_wdata;
  alp_pkg::point_t                rd;

  logic signed [DIFF_W-1:0]       sel_d;
  logic signed [SQ_W-1:0]         sq_w;
  logic [SQ_W-1:0]                acc_sum;
  logic                           sq_start;
  logic                           sq_done;
  logic [ROOT_W-1:0]              root;
  logic [DIST_W:0]                d_sum;
  logic [DIST_W-1:0]              d_sat;
  logic                           keep_w;

  logic signed [POS_W-1:0]        a0, a1;
  logic signed [DIFF_W-1:0]       diff_w;
  logic signed [PROD_W-1:0]       prod_w;
  logic [PROD_W-1:0]              prod_mag;
  logic                           div_start;
  logic                           div_done;
  logic [QUO_W-1:0]               quo;
  logic signed [QUO_W:0]          quo_s;
  logic signed [QUO_W:0]          axis_sum;

  assign in_acc   = in_req.valid && in_req.ready;
  assign last_idx = IDX_W'(count_r - 1'b1);
  assign span     = hi_r - lo_r;
  assign mid_w    = lo_r + (span >> 1);

  // The read port is presented every cycle; the state picks the index so
  // that the entry it needs is on rd in the following cycle.
  always_comb begin
    case (state_r)
      S_IDLE:  rd_idx = (in_req.req_type == alp_pkg::REQ_QUERY ||
                         in_req.req_type == alp_pkg::REQ_TRIM) ? '0 : last_idx;
      S_B_LO:  rd_idx = last_idx;
      S_B_CHK: rd_idx = (span > IDX_W'(1)) ? mid_w : lo_r;
      S_Q_LO:  rd_idx = hi_r;
      default: rd_idx = last_idx;
    endcase
  end

  assign mem_raddr = slot_of(first_r, rd_idx);

  // Squared distance to the last point, one axis per cycle.
  always_comb begin
    case (sel_r)
      2'd0:    sel_d = dx_r;
      2'd1:    sel_d = dy_r;
      default: sel_d = dz_r;
    endcase
  end

  assign sq_w     = sel_d * sel_d;
  assign acc_sum  = acc_r + SQ_W'(sq_w);
  assign sq_start = (state_r == S_APP_SQ) && (sel_r == 2'd2);

  assign d_sum  = {1'b0, last_d_r} + (DIST_W+1)'(root);
  assign d_sat  = d_sum[DIST_W] ? {DIST_W{1'b1}} : d_sum[DIST_W-1:0];
  assign keep_w = root >= ROOT_W'(min_step_r);

  // Memory writes happen only when an append completes; every read of the
  // same request comes before it, so no forwarding is needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_of(first_r, IDX_W'(count_r));
    mem_wdata = '{x: px_r, y: py_r, z: pz_r, d: d_sat};
    if (state_r == S_IDLE) begin
      mem_we    = in_acc && in_req.req_type == alp_pkg::REQ_APPEND && count_r == '0;
      mem_waddr = first_r;
      mem_wdata = '{x: in_req.pos_x, y: in_req.pos_y, z: in_req.pos_z, d: '0};
    end else if (state_r == S_APP_RT) begin
      mem_we = sq_done && keep_w;
    end
  end

  // Interpolation: out = p1 + (p0 - p1) * num / den, truncated toward zero.
  always_comb begin
    case (axis_r)
      2'd0:    begin a0 = p0_r.x; a1 = p1_r.x; end
      2'd1:    begin a0 = p0_r.y; a1 = p1_r.y; end
      default: begin a0 = p0_r.z; a1 = p1_r.z; end
    endcase
  end

  assign diff_w    = DIFF_W'(a0) - DIFF_W'(a1);
  assign prod_w    = diff_w * $signed({1'b0, num_r});
  assign prod_mag  = neg_r ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign div_start = (state_r == S_Q_DST);
  assign quo_s     = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign axis_sum  = (QUO_W+1)'(a1) + quo_s;

  alp_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  alp_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_sum),
    .done     (sq_done),
    .root     (root)
  );

  alp_div #(
    .DEN_W (DIST_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag[DIST_W+QUO_W-1:0]),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r <= alp_pkg::MIN_STEP_RST;
      margin_r   <= alp_pkg::MARGIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        alp_pkg::CFG_MIN_STEP:       min_step_r <= cfg_wdata[alp_pkg::MIN_STEP_W-1:0];
        alp_pkg::CFG_DISCARD_MARGIN: margin_r   <= cfg_wdata[alp_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      first_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r      <= in_req.req_type;
            px_r       <= in_req.pos_x;
            py_r       <= in_req.pos_y;
            pz_r       <= in_req.pos_z;
            dist_r     <= in_req.dist_req;
            res_ok_r   <= 1'b0;
            res_x_r    <= '0;
            res_y_r    <= '0;
            res_z_r    <= '0;
            res_dist_r <= '0;
            state_r    <= S_RESP;
            case (in_req.req_type)
              alp_pkg::REQ_CLEAR: begin
                count_r  <= '0;
                first_r  <= '0;
                res_ok_r <= 1'b1;
              end
              alp_pkg::REQ_APPEND: begin
                if (count_r == '0) begin
                  count_r  <= CNT_W'(1);
                  res_ok_r <= 1'b1;
                end else if (count_r != MAX_CNT) begin
                  state_r <= S_APP_DIF;
                end
              end
              alp_pkg::REQ_QUERY, alp_pkg::REQ_TRIM: begin
                if (count_r != '0) begin
                  state_r <= S_B_LO;
                end
              end
              alp_pkg::REQ_READ: begin
                res_ok_r <= 1'b1;
                if (count_r != '0) begin
                  state_r <= S_RD_WT;
                end
              end
              default: ;
            endcase
          end
        end
        S_APP_DIF: begin
          dx_r     <= DIFF_W'(px_r) - DIFF_W'(rd.x);
          dy_r     <= DIFF_W'(py_r) - DIFF_W'(rd.y);
          dz_r     <= DIFF_W'(pz_r) - DIFF_W'(rd.z);
          last_d_r <= rd.d;
          acc_r    <= '0;
          sel_r    <= 2'd0;
          state_r  <= S_APP_SQ;
        end
        S_APP_SQ: begin
          acc_r <= acc_sum;
          sel_r <= sel_r + 2'd1;
          if (sel_r == 2'd2) begin
            state_r <= S_APP_RT;
          end
        end
        S_APP_RT: begin
          if (sq_done) begin
            res_ok_r <= 1'b1;
            if (keep_w) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_RESP;
          end
        end
        S_RD_WT: begin
          res_dist_r <= rd.d;
          state_r    <= S_RESP;
        end
        S_B_LO: begin
          state_r <= (dist_r < rd.d) ? S_RESP : S_B_HI;
        end
        S_B_HI: begin
          lo_r    <= '0;
          hi_r    <= last_idx;
          state_r <= (dist_r > rd.d) ? S_RESP : S_B_CHK;
        end
        S_B_CHK: begin
          mid_r <= mid_w;
          if (span > IDX_W'(1)) begin
            state_r <= S_B_MID;
          end else if (req_r == alp_pkg::REQ_TRIM) begin
            if (CMP_W'(lo_r) > CMP_W'(margin_r)) begin
              first_r  <= slot_of(first_r, lo_r);
              count_r  <= count_r - CNT_W'(lo_r);
              res_ok_r <= 1'b1;
            end
            state_r <= S_RESP;
          end else begin
            state_r <= S_Q_LO;
          end
        end
        S_B_MID: begin
          if (rd.d == dist_r) begin
            lo_r <= mid_r;
            hi_r <= mid_r;
          end else if (rd.d > dist_r) begin
            hi_r <= mid_r;
          end else begin
            lo_r <= mid_r;
          end
          state_r <= S_B_CHK;
        end
        S_Q_LO: begin
          p0_r    <= rd;
          state_r <= S_Q_HI;
        end
        S_Q_HI: begin
          res_ok_r <= 1'b1;
          p1_r     <= rd;
          num_r    <= rd.d - dist_r;
          den_r    <= rd.d - p0_r.d;
          axis_r   <= 2'd0;
          if (lo_r == hi_r || rd.d <= p0_r.d) begin
            res_x_r <= p0_r.x;
            res_y_r <= p0_r.y;
            res_z_r <= p0_r.z;
            state_r <= S_RESP;
          end else begin
            state_r <= S_Q_MUL;
          end
        end
        S_Q_MUL: begin
          prod_r  <= prod_w;
          neg_r   <= prod_w[PROD_W-1];
          state_r <= S_Q_DST;
        end
        S_Q_DST: begin
          state_r <= S_Q_DIV;
        end
        S_Q_DIV: begin
          if (div_done) begin
            state_r <= S_Q_ACC;
          end
        end
        S_Q_ACC: begin
          case (axis_r)
            2'd0:    res_x_r <= axis_sum[POS_W-1:0];
            2'd1:    res_y_r <= axis_sum[POS_W-1:0];
            default: res_z_r <= axis_sum[POS_W-1:0];
          endcase
          axis_r  <= axis_r + 2'd1;
          state_r <= (axis_r == 2'd2) ? S_RESP : S_Q_MUL;
        end
        S_RESP: begin
          if (!out_valid_r || out_rsp.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && (!out_valid_r || out_rsp.ready)) begin
      out_valid_r <= 1'b1;
      out_ok_r    <= res_ok_r;
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_z_r     <= res_z_r;
      out_dist_r  <= res_dist_r;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_req.ready     = (state_r == S_IDLE);
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.ok       = out_ok_r;
  assign out_rsp.out_x    = out_x_r;
  assign out_rsp.out_y    = out_y_r;
  assign out_rsp.out_z    = out_z_r;
  assign out_rsp.out_dist = out_dist_r;

  // The store never holds more points than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT) else $error("point count above capacity");

  // A clear leaves an empty store starting at slot zero.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.req_type == alp_pkg::REQ_CLEAR) |=> (count_r == '0 && first_r == '0))
    else $error("clear did not empty the store");

  // An append to a full store changes nothing.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.req_type == alp_pkg::REQ_APPEND && count_r == MAX_CNT) |=>
    $stable(count_r)) else $error("append to full store changed the count");

  // A finished result waits while the output register is still taken.
  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_rsp.ready) |=> state_r == S_RESP)
    else $error("result overwrote a pending output");

endmodule
